// File: rtl/wildcard_byte_pattern_scanner_macros.svh
// Assertion macros used by the scanner's checker file
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH

// Property checked at every clock edge outside reset
`define WBPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every clock edge, reset included
`define WBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/wbps_pkg.sv
// Shared constants, types and helpers of the wildcard byte pattern scanner
package wbps_pkg;

    // Number of match cells in the chain
    localparam int MAX_PATTERN = 16;
    // Pattern bytes held in the two pattern registers
    localparam int PAT_BYTES   = 16;

    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 64;
    localparam int DATA_W      = 64;
    localparam int LEN_W       = 5;
    localparam int CFG_ADDR_W  = 5;
    localparam int REG_IDX_W   = 2;
    localparam int EFF_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Register indexes (byte address is 8 * index)
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_REGION_BASE    = 2'd3;

    // Per-word control broadcast to every cell
    typedef struct packed {
        logic advance;   // a word is taken this cycle
        logic clear;     // word is the last of the region
    } cell_ctrl_t;

    // Pattern byte i; bytes past the register pair act as wildcards
    function automatic logic [BYTE_W-1:0] pattern_byte(
        input logic [PAT_BYTES*BYTE_W-1:0] pattern,
        input int unsigned                 i
    );
        logic [BYTE_W-1:0] b;
        b = '0;
        if (i < PAT_BYTES)
        begin
            b = pattern[BYTE_W*i +: BYTE_W];
        end
        return b;
    endfunction

endpackage

// File: rtl/wbps_cell.sv
// One cell of the shift-and match chain: holds one partial match bit
module wbps_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  wbps_pkg::cell_ctrl_t      ctrl,
    input  logic [wbps_pkg::BYTE_W-1:0] data_byte,
    input  logic [wbps_pkg::BYTE_W-1:0] pat_byte,
    input  logic                      prev_bit,
    output logic                      match_next,
    output logic                      match_bit
);
    import wbps_pkg::*;

    logic match_reg;
    logic match_reg_next;
    logic byte_ok;

    // Zero pattern byte matches anything
    assign byte_ok    = (pat_byte == '0) || (pat_byte == data_byte);
    assign match_next = prev_bit & byte_ok;
    assign match_bit  = match_reg;

    // Advance on each word, drop back to empty after the region's last word
    always_comb
    begin
        match_reg_next = match_reg;
        if (ctrl.advance)
        begin
            match_reg_next = ctrl.clear ? 1'b0 : match_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_reg_next;
        end
    end

endmodule

// File: rtl/wildcard_byte_pattern_scanner.sv
// Top level: config registers, match cell chain, offset counter and result register
// A result is registered: out_valid rises in the cycle after the word that causes it is taken.
// Throughput: one byte per cycle; the chain of cells updates every partial match
// at once, and in_ready drops only while an unread result sits in the output register.
// Reset (rst_n low, asynchronous): registers, match bits, offset and result clear.
module wildcard_byte_pattern_scanner (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wbps_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [wbps_pkg::DATA_W-1:0]   pwdata,
    output logic [wbps_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // byte stream in
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wbps_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          last_byte,
    // result out
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [wbps_pkg::ADDR_W-1:0]   match_address
);
    import wbps_pkg::*;

    logic [DATA_W-1:0]  pattern_low_reg;
    logic [DATA_W-1:0]  pattern_high_reg;
    logic [LEN_W-1:0]   pattern_length_reg;
    logic [ADDR_W-1:0]  region_base_reg;

    logic [ADDR_W-1:0]  offset_reg;
    logic [ADDR_W-1:0]  offset_reg_next;
    logic               reported_reg;
    logic               reported_reg_next;
    logic               out_valid_reg;
    logic               out_valid_reg_next;
    logic               found_reg;
    logic               found_reg_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_reg_next;

    logic                        cfg_write;
    logic [REG_IDX_W-1:0]        reg_idx;
    logic                        in_fire;
    cell_ctrl_t                  ctrl;
    logic [PAT_BYTES*BYTE_W-1:0] pattern;
    logic [MAX_PATTERN-1:0]      chain_next;
    logic [MAX_PATTERN-1:0]      chain_bits;
    logic [EFF_W-1:0]            eff_len;
    logic [IDX_W-1:0]            tail_idx;
    logic                        hit;
    logic                        emit_found;
    logic                        emit_miss;
    logic [ADDR_W-1:0]           start_addr;

    // Configuration port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[CFG_ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            region_base_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_PATTERN_LOW:    pattern_low_reg    <= pwdata;
                REG_PATTERN_HIGH:   pattern_high_reg   <= pwdata;
                REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[LEN_W-1:0];
                REG_REGION_BASE:    region_base_reg    <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PATTERN_LOW:    prdata = pattern_low_reg;
            REG_PATTERN_HIGH:   prdata = pattern_high_reg;
            REG_PATTERN_LENGTH: prdata = DATA_W'(pattern_length_reg);
            REG_REGION_BASE:    prdata = region_base_reg;
            default:            prdata = '0;
        endcase
    end

    // Stream handshake: take a word unless a result is stuck in the output
    assign in_ready     = !out_valid_reg || out_ready;
    assign in_fire      = in_valid && in_ready;
    assign ctrl.advance = in_fire;
    assign ctrl.clear   = last_byte;
    assign pattern      = {pattern_high_reg, pattern_low_reg};

    // Chain of match cells; cell 0 always starts a new candidate
    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        logic prev;
        if (i == 0)
        begin : g_head
            assign prev = 1'b1;
        end
        else
        begin : g_link
            assign prev = chain_bits[i-1];
        end

        wbps_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .data_byte  (data_byte),
            .pat_byte   (pattern_byte(pattern, i)),
            .prev_bit   (prev),
            .match_next (chain_next[i]),
            .match_bit  (chain_bits[i])
        );
    end

    // Effective length saturates at the chain depth
    always_comb
    begin
        if (int'(pattern_length_reg) > MAX_PATTERN)
        begin
            eff_len = EFF_W'(MAX_PATTERN);
        end
        else
        begin
            eff_len = EFF_W'(pattern_length_reg);
        end
    end

    assign tail_idx   = IDX_W'(eff_len - EFF_W'(1));
    assign hit        = (eff_len != '0) && chain_next[tail_idx];
    assign emit_found = !reported_reg && hit;
    assign emit_miss  = !reported_reg && !hit && last_byte;
    assign start_addr = region_base_reg + offset_reg - ADDR_W'(eff_len - EFF_W'(1));

    // Scan state and result register
    always_comb
    begin
        offset_reg_next    = offset_reg;
        reported_reg_next  = reported_reg;
        out_valid_reg_next = out_valid_reg && !out_ready;
        found_reg_next     = found_reg;
        addr_reg_next      = addr_reg;
        if (in_fire)
        begin
            offset_reg_next   = last_byte ? '0 : offset_reg + ADDR_W'(1);
            reported_reg_next = last_byte ? 1'b0 : (reported_reg || hit);
            if (emit_found || emit_miss)
            begin
                out_valid_reg_next = 1'b1;
                found_reg_next     = emit_found;
                addr_reg_next      = emit_found ? start_addr : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            addr_reg      <= '0;
        end
        else
        begin
            offset_reg    <= offset_reg_next;
            reported_reg  <= reported_reg_next;
            out_valid_reg <= out_valid_reg_next;
            found_reg     <= found_reg_next;
            addr_reg      <= addr_reg_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = addr_reg;

endmodule

// File: rtl/wbps_checker.sv
// Port-level checker for the scanner, bound to the top level
`include "wildcard_byte_pattern_scanner_macros.svh"

module wbps_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          found,
    input logic [wbps_pkg::ADDR_W-1:0]   match_address
);
    import wbps_pkg::*;

    // A result waiting to be taken holds still
    `WBPS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_address), "result word changed while stalled")

    // A not-found word carries a zero address
    `WBPS_ASSERT(a_miss_zero, clk, rst_n, out_valid && !found |-> match_address == '0, "not-found word with nonzero address")

    // An empty output never blocks the input side
    `WBPS_ASSERT(a_ready_free, clk, rst_n, !out_valid |-> in_ready, "input stalled with empty output")

    // No result is shown once reset has been seen at an edge
    `WBPS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result valid during reset")

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .match_address (match_address)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the wildcard byte pattern scanner
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wbps_pkg::*;

    localparam int IDLE_PCT    = 9;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 4;
    localparam int ITEM_TARGET = 600;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } scan_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic                  last_byte = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  found;
    logic [ADDR_W-1:0]     match_address;

    // predictor copy of the registers
    logic [63:0]           sig_low = '0;
    logic [63:0]           sig_high = '0;
    logic [LEN_W-1:0]      sig_len = '0;
    logic [ADDR_W-1:0]     base_addr = '0;
    // predictor copy of the scan state
    logic [MAX_PATTERN-1:0] match_vec = '0;
    logic [ADDR_W-1:0]     scan_offset = '0;
    logic                  hit_reported = 1'b0;

    scan_result_t          pending_results[$];
    logic [BYTE_W-1:0]     region_q[$];

    int                    mismatches = 0;
    int                    words_sent = 0;
    int                    n_found = 0;
    int                    n_missed = 0;
    int                    n_configs = 0;
    int                    hold_left = 0;
    bit                    steady = 1'b0;
    int                    idle_cycles = 0;

    wildcard_byte_pattern_scanner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_address (match_address)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Signature byte i as currently configured
    function automatic logic [7:0] sig_byte_at(input int i);
        logic [127:0] sig;
        sig = {sig_high, sig_low};
        return sig[8*i +: 8];
    endfunction

    // Shift-and update for one word; queues the result it causes, if any
    function automatic void predict_scan_result(input logic [7:0] b, input logic lst);
        logic [MAX_PATTERN-1:0] hits;
        logic [7:0]             pb;
        int                     eff;
        scan_result_t           r;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pb = sig_byte_at(i);
            hits[i] = (pb == 8'h00) || (pb == b);
        end
        match_vec = {match_vec[MAX_PATTERN-2:0], 1'b1} & hits;
        eff = (sig_len > MAX_PATTERN) ? MAX_PATTERN : int'(sig_len);
        if (!hit_reported && eff != 0 && match_vec[eff-1])
        begin
            hit_reported = 1'b1;
            r.found = 1'b1;
            r.addr = base_addr + scan_offset - ADDR_W'(eff - 1);
            pending_results = {pending_results, r};
        end
        else if (lst && !hit_reported)
        begin
            r.found = 1'b0;
            r.addr = '0;
            pending_results = {pending_results, r};
        end
        scan_offset = scan_offset + ADDR_W'(1);
        if (lst)
        begin
            match_vec = '0;
            scan_offset = '0;
            hit_reported = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        scan_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result found=%0b addr=%h",
                                          found, match_address));
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (found !== exp_r.found)
                    report_mismatch($sformatf("found %0b, expected %0b", found, exp_r.found));
                if (match_address !== exp_r.addr)
                    report_mismatch($sformatf("match_address %h, expected %h",
                                              match_address, exp_r.addr));
                if (exp_r.found)
                    n_found++;
                else
                    n_missed++;
            end
        end
    end

    // Receiver: random stalls, a counted hold-off, or always ready
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog on cycles with no accepted word, taken result or register write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pwrite))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Register write: setup phase, then access phase
    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_PATTERN_LOW:    sig_low = value;
            REG_PATTERN_HIGH:   sig_high = value;
            REG_PATTERN_LENGTH: sig_len = value[LEN_W-1:0];
            REG_REGION_BASE:    base_addr = value;
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [63:0] len, input logic [63:0] base);
        write_register(REG_PATTERN_LOW, lo);
        write_register(REG_PATTERN_HIGH, hi);
        write_register(REG_PATTERN_LENGTH, len);
        write_register(REG_REGION_BASE, base);
        n_configs++;
    endtask

    // Send one word, with random gaps unless in a steady stretch
    task automatic send_byte(input logic [7:0] b, input logic lst);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        predict_scan_result(b, lst);
        words_sent++;
    endtask

    // Stop sending and let every expected result arrive
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Send region_q as one region; optionally drain before word pause_at
    task automatic send_region(input int pause_at);
        for (int j = 0; j < region_q.size(); j++)
        begin
            if (j == pause_at)
                wait_idle();
            send_byte(region_q[j], j == region_q.size() - 1);
        end
    endtask

    function automatic logic [7:0] filler_byte();
        if ($urandom_range(0, 1))
            return sig_byte_at($urandom_range(0, MAX_PATTERN - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    // Region with the signature embedded, a broken copy of it, or pure noise
    task automatic build_random_region();
        int         eff;
        int         rlen;
        int         pos;
        int         kind;
        logic [7:0] pb;
        eff = (sig_len > MAX_PATTERN) ? MAX_PATTERN : int'(sig_len);
        kind = $urandom_range(0, 9);
        rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
        if (kind < 9 && eff > rlen)
            rlen = eff + $urandom_range(0, 8);
        region_q.delete();
        for (int j = 0; j < rlen; j++)
            region_q = {region_q, filler_byte()};
        if (kind < 9 && eff > 0)
        begin
            pos = $urandom_range(0, rlen - eff);
            for (int j = 0; j < eff; j++)
            begin
                pb = sig_byte_at(j);
                if (pb != 8'h00)
                    region_q[pos + j] = pb;
            end
            // broken copy: spoil the final signature byte
            if (kind >= 7 && sig_byte_at(eff - 1) != 8'h00)
                region_q[pos + eff - 1] = sig_byte_at(eff - 1) ^ 8'h01;
        end
    endtask

    task automatic random_config();
        logic [127:0] sig;
        logic [63:0]  len;
        logic [63:0]  base;
        for (int i = 0; i < 16; i++)
        begin
            case ($urandom_range(0, 3))
                0:       sig[8*i +: 8] = 8'h00;
                1:       sig[8*i +: 8] = 8'hFF;
                default: sig[8*i +: 8] = 8'($urandom_range(1, 255));
            endcase
        end
        case ($urandom_range(0, 5))
            0:       len = 0;
            1:       len = 1;
            2:       len = 16;
            3:       len = 31;
            default: len = $urandom_range(0, 31);
        endcase
        case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = '1;
            default: base = {$urandom, $urandom};
        endcase
        load_config(sig[63:0], sig[127:64], len, base);
    endtask

    // Extremes of the fields and each special case of the scan
    task automatic test_directed();
        // zero length after reset: region ends with not-found
        region_q = '{8'h00, 8'hFF};
        send_region(-1);
        wait_idle();
        // signature DE AD ?? EF
        load_config(64'h0000_0000_EF00_ADDE, 64'h0, 4, 64'h1000);
        // match at the region start, trailing words ignored
        region_q = '{8'hDE, 8'hAD, 8'h55, 8'hEF, 8'h77, 8'h88};
        send_region(-1);
        // match completes on the final word
        region_q = '{8'hDE, 8'hAD, 8'h00, 8'hEF};
        send_region(-1);
        // region shorter than the signature
        region_q = '{8'hDE, 8'hAD};
        send_region(-1);
        wait_idle();
        // length above 16 saturates; top byte only, base at all ones
        load_config(64'h0, 64'hFF00_0000_0000_0000, 31, '1);
        region_q.delete();
        repeat (15) region_q = {region_q, 8'h5A};
        region_q = {region_q, 8'hFF};
        send_region(-1);
        wait_idle();
    endtask

    // Long stretch with no idling on either side
    task automatic test_steady_stream();
        steady = 1'b1;
        random_config();
        repeat (8)
        begin
            build_random_region();
            send_region(-1);
        end
        wait_idle();
        steady = 1'b0;
    endtask

    // Receiver holds off while one-word regions keep coming
    task automatic test_backpressure();
        load_config(64'h0, 64'h0, 1, {$urandom, $urandom});
        hold_left = HOLD_CYCLES;
        repeat (20)
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        wait_idle();
    endtask

    // Sender drains all results partway through regions
    task automatic test_sender_pause();
        random_config();
        repeat (4)
        begin
            build_random_region();
            send_region($urandom_range(0, region_q.size() - 1));
        end
        wait_idle();
    endtask

    task automatic test_random_regions();
        while (words_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                wait_idle();
                random_config();
            end
            build_random_region();
            if ($urandom_range(0, 19) == 0)
                send_region($urandom_range(0, region_q.size() - 1));
            else
                send_region(-1);
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_steady_stream();
        test_backpressure();
        test_sender_pause();
        test_random_regions();

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        $display("Scanned %0d words under %0d register settings", words_sent, n_configs);
        $display("Results: %0d matches, %0d not-found, %0d mismatches",
                 n_found, n_missed, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
